/* design/lrf_pkg.sv */
`default_nettype none

package lrf_pkg;

  localparam int unsigned WordW       = 24;
  localparam int unsigned AddrW       = 48;
  localparam int unsigned LocW        = 7;
  localparam int unsigned FuncW       = 2;
  localparam int unsigned CfgW        = 6;
  localparam int unsigned MaxWordsDef = 32;

  localparam logic [LocW-1:0] LocNone       = LocW'(73);
  localparam logic [CfgW-1:0] RecWordsReset = CfgW'(32);

  typedef enum logic [FuncW-1:0] {
    FUNC_DATA   = 2'd0,
    FUNC_ORIGIN = 2'd1,
    FUNC_END    = 2'd2,
    FUNC_FLUSH  = 2'd3
  } func_e;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_HDR_CNT,
    ST_HDR_CHK,
    ST_HDR_AHI,
    ST_HDR_ALO,
    ST_DATA,
    ST_UPDATE,
    ST_FINISH,
    ST_RESUM
  } state_e;

  // Ones' complement add of two 24-bit words. One fold is enough because the
  // folded carry can never produce a second carry.
  function automatic logic [WordW-1:0] eac_add(input logic [WordW-1:0] a,
                                               input logic [WordW-1:0] b);
    logic [WordW:0] s;
    s = {1'b0, a} + {1'b0, b};
    return s[WordW-1:0] + {{(WordW-1){1'b0}}, s[WordW]};
  endfunction

endpackage

`default_nettype wire

/* design/load_record_framer_unit.sv */
`default_nettype none

// Channel   | Direction | Handshake              | Payload
// ----------+-----------+------------------------+-------------------------------------------
// input     | in        | in_valid_i/in_stall_o  | func_i, included_i, locator_i,
//           |           |                        | load_address_i, data_word_i
// output    | out       | out_valid_o/out_stall_i| out_word_o, record_last_o, run_last_o
// config    | in        | cfg_we_i               | cfg_data_i (record_words)
//
// An item that is neither selected nor a flush is dropped while idle. A data word that
// closes no record is accepted, then written to the buffer in the update state. A record
// moves out at one word per cycle unless stalled, four header words plus its data words,
// read from the word buffer one entry ahead of the output register; reopening a record
// after a full or flushed one passes through the finish and resume states. The word
// buffer is not cleared at reset: only entries written for the pending record are ever
// read. Output stalls hold the output register and pause the sequencer; the input is
// stalled whenever the sequencer is busy.
module load_record_framer_unit #(
  parameter int unsigned MaxWords = lrf_pkg::MaxWordsDef
) (
  input  wire logic                        clk_i,
  input  wire logic                        rst_ni,
  // configuration
  input  wire logic                        cfg_we_i,
  input  wire logic [lrf_pkg::CfgW-1:0]    cfg_data_i,
  // input channel
  input  wire logic                        in_valid_i,
  output      logic                        in_stall_o,
  input  wire logic [lrf_pkg::FuncW-1:0]   func_i,
  input  wire logic                        included_i,
  input  wire logic [lrf_pkg::LocW-1:0]    locator_i,
  input  wire logic [lrf_pkg::AddrW-1:0]   load_address_i,
  input  wire logic [lrf_pkg::WordW-1:0]   data_word_i,
  // output channel
  output      logic                        out_valid_o,
  input  wire logic                        out_stall_i,
  output      logic [lrf_pkg::WordW-1:0]   out_word_o,
  output      logic                        record_last_o,
  output      logic                        run_last_o
);
  import lrf_pkg::*;

  localparam int unsigned IdxW = (MaxWords > 1) ? $clog2(MaxWords) : 1;
  localparam int unsigned CntW = $clog2(MaxWords + 1);
  localparam int unsigned LimW = CfgW + 1;

  // Architectural state of the pending record.
  state_e              state_q, state_d;
  logic [CntW-1:0]     count_q, count_d;
  logic [WordW-1:0]    sum_q, sum_d;
  logic [AddrW-1:0]    addr_q, addr_d;
  logic [LocW-1:0]     last_loc_q, last_loc_d;
  logic [CfgW-1:0]     rec_words_q;
  // post_q: a second record follows the current one for this item.
  // emit_post_q: the record now going out is that second one.
  logic                post_q, post_d;
  logic                emit_post_q, emit_post_d;

  // Captured item.
  func_e               func_q;
  logic [LocW-1:0]     loc_q;
  logic [AddrW-1:0]    item_addr_q;
  logic [WordW-1:0]    item_word_q;
  logic                newloc_q;

  // Output register.
  logic                out_valid_q, out_valid_d;
  logic [WordW-1:0]    out_word_q, out_word_d;
  logic                rec_last_q, rec_last_d;
  logic                run_last_q, run_last_d;

  // Word buffer.
  logic [WordW-1:0]    word_mem [MaxWords];
  logic [WordW-1:0]    rdata_q;
  logic                mem_we;
  logic [IdxW-1:0]     mem_wa;
  logic                rd_en;
  logic [IdxW-1:0]     rd_addr;
  logic [IdxW-1:0]     rd_idx_q, rd_idx_d;

  // Shared combinational terms.
  func_e               in_func;
  logic                accept;
  logic                relevant;
  logic                in_newloc;
  logic                ld;
  logic                rd_last;
  logic                emit_done;
  logic [LimW-1:0]     limit;
  logic [LimW-1:0]     next_cnt;
  logic [WordW-1:0]    open_sum;
  logic [WordW-1:0]    chk_word;

  assign in_func   = func_e'(func_i);
  assign accept    = in_valid_i && (state_q == ST_IDLE);
  assign relevant  = included_i || (in_func == FUNC_FLUSH);
  assign in_newloc = (locator_i != last_loc_q);
  assign ld        = !out_valid_q || !out_stall_i;
  assign rd_last   = ((CntW'(rd_idx_q) + CntW'(1)) == count_q);
  assign emit_done = ld && (((state_q == ST_HDR_ALO) && (count_q == '0)) ||
                            ((state_q == ST_DATA) && rd_last));

  // Effective word limit: zero acts as one, large values saturate.
  always_comb begin
    if (rec_words_q == '0) begin
      limit = LimW'(1);
    end else if (LimW'(rec_words_q) > LimW'(MaxWords)) begin
      limit = LimW'(MaxWords);
    end else begin
      limit = LimW'(rec_words_q);
    end
  end

  // Count after appending the incoming data word, judged at acceptance.
  assign next_cnt = (in_newloc ? LimW'(0) : LimW'(count_q)) + LimW'(1);

  assign open_sum = eac_add(item_addr_q[WordW-1:0], item_addr_q[AddrW-1:WordW]);
  assign chk_word = ~eac_add(sum_q, WordW'(count_q));

  // Next-state logic.
  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_IDLE: begin
        if (accept && relevant) begin
          case (in_func)
            FUNC_DATA: begin
              state_d = (in_newloc && (count_q != '0)) ? ST_HDR_CNT : ST_UPDATE;
            end
            FUNC_ORIGIN, FUNC_END: begin
              state_d = (count_q != '0) ? ST_HDR_CNT : ST_UPDATE;
            end
            FUNC_FLUSH: begin
              state_d = (count_q != '0) ? ST_HDR_CNT : ST_IDLE;
            end
            default: state_d = ST_IDLE;
          endcase
        end
      end
      ST_HDR_CNT: if (ld) state_d = ST_HDR_CHK;
      ST_HDR_CHK: if (ld) state_d = ST_HDR_AHI;
      ST_HDR_AHI: if (ld) state_d = ST_HDR_ALO;
      ST_HDR_ALO, ST_DATA: begin
        if (emit_done) begin
          state_d = emit_post_q ? ST_FINISH : ST_UPDATE;
        end else if (ld) begin
          state_d = ST_DATA;
        end
      end
      ST_UPDATE: state_d = post_q ? ST_HDR_CNT : ST_IDLE;
      ST_FINISH: state_d = (func_q == FUNC_END) ? ST_IDLE : ST_RESUM;
      ST_RESUM:  state_d = ST_IDLE;
      default:   state_d = ST_IDLE;
    endcase
  end

  // Datapath and output logic.
  always_comb begin
    count_d     = count_q;
    sum_d       = sum_q;
    addr_d      = addr_q;
    last_loc_d  = last_loc_q;
    post_d      = post_q;
    emit_post_d = emit_post_q;
    out_valid_d = ld ? 1'b0 : out_valid_q;
    out_word_d  = out_word_q;
    rec_last_d  = rec_last_q;
    run_last_d  = run_last_q;
    mem_we      = 1'b0;
    mem_wa      = '0;
    rd_en       = 1'b0;
    rd_addr     = '0;
    rd_idx_d    = rd_idx_q;
    in_stall_o  = (state_q != ST_IDLE);

    case (state_q)
      ST_IDLE: begin
        if (accept && relevant) begin
          emit_post_d = (in_func == FUNC_FLUSH);
          case (in_func)
            FUNC_DATA:   post_d = (next_cnt >= limit);
            FUNC_ORIGIN: post_d = 1'b0;
            FUNC_END:    post_d = 1'b1;
            FUNC_FLUSH:  post_d = 1'b1;
            default:     post_d = 1'b0;
          endcase
        end
      end
      ST_HDR_CNT: begin
        if (ld) begin
          out_valid_d = 1'b1;
          out_word_d  = WordW'(count_q);
          rec_last_d  = 1'b0;
          run_last_d  = 1'b0;
        end
      end
      ST_HDR_CHK: begin
        if (ld) begin
          out_valid_d = 1'b1;
          out_word_d  = chk_word;
          rec_last_d  = 1'b0;
          run_last_d  = 1'b0;
        end
      end
      ST_HDR_AHI: begin
        if (ld) begin
          out_valid_d = 1'b1;
          out_word_d  = addr_q[AddrW-1:WordW];
          rec_last_d  = 1'b0;
          run_last_d  = 1'b0;
        end
      end
      ST_HDR_ALO: begin
        if (ld) begin
          out_valid_d = 1'b1;
          out_word_d  = addr_q[WordW-1:0];
          rec_last_d  = (count_q == '0);
          run_last_d  = (count_q == '0) && (emit_post_q || !post_q);
          if (count_q != '0) begin
            rd_en    = 1'b1;
            rd_addr  = '0;
            rd_idx_d = '0;
          end
        end
      end
      ST_DATA: begin
        if (ld) begin
          out_valid_d = 1'b1;
          out_word_d  = rdata_q;
          rec_last_d  = rd_last;
          run_last_d  = rd_last && (emit_post_q || !post_q);
          if (!rd_last) begin
            rd_en    = 1'b1;
            rd_addr  = rd_idx_q + IdxW'(1);
            rd_idx_d = rd_idx_q + IdxW'(1);
          end
        end
      end
      ST_UPDATE: begin
        emit_post_d = 1'b1;
        case (func_q)
          FUNC_DATA: begin
            if (newloc_q) begin
              addr_d     = item_addr_q;
              last_loc_d = loc_q;
              sum_d      = eac_add(open_sum, item_word_q);
              count_d    = CntW'(1);
              mem_we     = 1'b1;
              mem_wa     = '0;
            end else begin
              sum_d   = eac_add(sum_q, item_word_q);
              count_d = count_q + CntW'(1);
              mem_we  = (count_q < CntW'(MaxWords));
              mem_wa  = count_q[IdxW-1:0];
            end
          end
          FUNC_ORIGIN, FUNC_END: begin
            addr_d     = item_addr_q;
            last_loc_d = loc_q;
            sum_d      = open_sum;
            count_d    = '0;
          end
          default: begin
          end
        endcase
      end
      ST_FINISH: begin
        // A transfer record leaves the record it opened untouched.
        if (func_q != FUNC_END) begin
          addr_d  = addr_q + AddrW'(count_q);
          count_d = '0;
        end
      end
      ST_RESUM: begin
        sum_d = eac_add(addr_q[WordW-1:0], addr_q[AddrW-1:WordW]);
      end
      default: begin
      end
    endcase
  end

  // Control and record state.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      count_q     <= '0;
      sum_q       <= '0;
      addr_q      <= '0;
      last_loc_q  <= LocNone;
      rec_words_q <= RecWordsReset;
      post_q      <= 1'b0;
      emit_post_q <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      count_q     <= count_d;
      sum_q       <= sum_d;
      addr_q      <= addr_d;
      last_loc_q  <= last_loc_d;
      post_q      <= post_d;
      emit_post_q <= emit_post_d;
      out_valid_q <= out_valid_d;
      if (cfg_we_i) begin
        rec_words_q <= cfg_data_i;
      end
    end
  end

  // Payload registers.
  always_ff @(posedge clk_i) begin
    if (accept) begin
      func_q      <= in_func;
      loc_q       <= locator_i;
      item_addr_q <= load_address_i;
      item_word_q <= data_word_i;
      newloc_q    <= in_newloc;
    end
    out_word_q <= out_word_d;
    rec_last_q <= rec_last_d;
    run_last_q <= run_last_d;
    rd_idx_q   <= rd_idx_d;
  end

  // Word buffer with registered read port.
  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      word_mem[mem_wa] <= item_word_q;
    end
    if (rd_en) begin
      rdata_q <= word_mem[rd_addr];
    end
  end

  assign out_valid_o   = out_valid_q;
  assign out_word_o    = out_word_q;
  assign record_last_o = rec_last_q;
  assign run_last_o    = run_last_q;

`ifndef SYNTHESIS
  // The pending count never outgrows the buffer.
  a_count_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= CntW'(MaxWords))
    else $error("pending word count exceeds buffer depth");

  // A buffer write and a buffer read never share a cycle.
  a_mem_excl: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(mem_we && rd_en))
    else $error("word buffer written while a record is read out");

  // The last word of an item always closes a record.
  a_run_closes_record: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && run_last_o) |-> record_last_o)
    else $error("run_last without record_last");

  // A selected item keeps the sequencer busy on the next cycle.
  a_busy_after_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && !in_stall_o && included_i && (in_func != FUNC_FLUSH))
      |=> in_stall_o)
    else $error("selected item did not start the sequencer");
`endif

endmodule

`default_nettype wire
